// ===== rtl/tpt_pkg.sv =====
// Shared widths, item types and saturation helper for the twiddle parameter tuner.
package tpt_pkg;

  localparam int GAIN_FIELDS   = 3;
  localparam int NUM_GAINS_DEF = 3;

  localparam int ERR_W   = 32;
  localparam int DIST_W  = 20;
  localparam int GAIN_W  = 32;
  localparam int STEP_W  = 31;
  localparam int TOTAL_W = 33;
  localparam int ACT_W   = 2;
  localparam int GSUM_W  = GAIN_W + 2;
  localparam int SCALE_W = 15;
  localparam int FRAC_W  = 16;

  localparam int CFG_IDX_W  = 2;
  localparam int S_TDATA_W  = 152;
  localparam int M_TDATA_W  = 136;

  localparam logic [STEP_W-1:0]  STEP_RESET  = 31'd65536;
  localparam logic [SCALE_W-1:0] SCALE_Q16   = 15'd26214;   // 0.4, truncated
  localparam logic [DIST_W:0]    DIST_MARGIN = 21'd200;
  localparam logic [ERR_W-1:0]   ERR_RESET   = '1;

  localparam logic signed [GSUM_W-1:0] GSUM_MAX = 34'sh0_7FFF_FFFF;
  localparam logic signed [GSUM_W-1:0] GSUM_MIN = 34'sh3_8000_0000;
  localparam logic [GAIN_W-1:0]        GAIN_MAX = 32'h7FFF_FFFF;
  localparam logic [GAIN_W-1:0]        GAIN_MIN = 32'h8000_0000;

  typedef struct packed {
    logic [GAIN_FIELDS-1:0][GAIN_W-1:0] gain;
    logic [DIST_W-1:0]                  trial_distance;
    logic [ERR_W-1:0]                   trial_error;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } stage_t;

  typedef struct packed {
    logic [ACT_W-1:0]                   active_gain;
    logic [TOTAL_W-1:0]                 step_total;
    logic [GAIN_FIELDS-1:0][GAIN_W-1:0] next_gain;
  } result_t;

  function automatic logic [GAIN_W-1:0] sat_gain(input logic signed [GSUM_W-1:0] v);
    logic [GAIN_W-1:0] r;
    if (v > GSUM_MAX) begin
      r = GAIN_MAX;
    end else if (v < GSUM_MIN) begin
      r = GAIN_MIN;
    end else begin
      r = v[GAIN_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/tpt_in_reg.sv =====
// Input register stage: captures one trial transaction and holds it for the update stage.
module tpt_in_reg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  tpt_pkg::item_t              s_item,
  input  logic                        take,
  output tpt_pkg::stage_t             stage
);
  import tpt_pkg::*;

  logic  valid;
  item_t item;

  assign s_tready    = !valid || take;
  assign stage.valid = valid;
  assign stage.item  = item;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      valid <= 1'b1;
    end else if (take) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      item <= s_item;
    end
  end

endmodule

// ===== rtl/tpt_update.sv =====
// Tuner state, single-pass gain/step update and the result register.
module tpt_update #(
  parameter int NUM_GAINS = tpt_pkg::NUM_GAINS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_write,
  input  logic [tpt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tpt_pkg::STEP_W-1:0]   cfg_data,
  input  tpt_pkg::stage_t              stage,
  output logic                         take,
  output logic                         out_valid,
  input  logic                         out_ready,
  output tpt_pkg::result_t             out_res
);
  import tpt_pkg::*;

  localparam int IDX_W     = (NUM_GAINS > 1) ? $clog2(NUM_GAINS) : 1;
  localparam int RESET_CNT = (NUM_GAINS < GAIN_FIELDS) ? NUM_GAINS : GAIN_FIELDS;
  localparam logic [TOTAL_W-1:0] TOTAL_RESET =
    TOTAL_W'(RESET_CNT) * {{(TOTAL_W-STEP_W){1'b0}}, STEP_RESET};
  localparam int PROD_W = STEP_W + SCALE_W;

  logic                 baseline_taken;
  logic                 probe_up_done;
  logic                 probe_down_done;
  logic [IDX_W-1:0]     idx;
  logic [ERR_W-1:0]     best_error;
  logic [DIST_W-1:0]    baseline_distance;
  logic [STEP_W-1:0]    steps [NUM_GAINS];
  logic [TOTAL_W-1:0]   step_total;

  logic                 fire;
  logic [STEP_W-1:0]    step;
  logic [PROD_W-1:0]    prod;
  logic [STEP_W-1:0]    scaled;
  logic [GAIN_W-1:0]    sel_gain;
  logic signed [GSUM_W-1:0] gain_up;
  logic signed [GSUM_W-1:0] gain_dn;
  logic [GAIN_W-1:0]    new_gain;
  logic                 write_gain;
  logic                 improved;
  logic                 dist_ok;
  logic                 do_base;
  logic                 do_up;
  logic                 do_down;
  logic                 do_scale;
  logic                 move_on;
  logic [IDX_W-1:0]     idx_next;
  logic [TOTAL_W-1:0]   total_next;
  result_t              res_next;
  logic                 cfg_hit;
  logic [STEP_W-1:0]    cfg_old;

  assign take = !out_valid || out_ready;
  assign fire = stage.valid && take;

  always_comb begin
    step     = '0;
    sel_gain = '0;
    for (int i = 0; i < NUM_GAINS; i++) begin
      if (int'(idx) == i) begin
        step = steps[i];
      end
    end
    for (int i = 0; i < GAIN_FIELDS; i++) begin
      if (int'(idx) == i) begin
        sel_gain = stage.item.gain[i];
      end
    end

    prod    = {{SCALE_W{1'b0}}, step} * {{STEP_W{1'b0}}, SCALE_Q16};
    scaled  = STEP_W'(prod >> FRAC_W);
    gain_up = $signed({{2{sel_gain[GAIN_W-1]}}, sel_gain}) + $signed({3'b000, step});
    gain_dn = $signed({{2{sel_gain[GAIN_W-1]}}, sel_gain}) - $signed({2'b00, step, 1'b0});

    dist_ok  = ({1'b0, stage.item.trial_distance} + DIST_MARGIN) >
               {1'b0, baseline_distance};
    improved = (stage.item.trial_error < best_error) && dist_ok;

    do_base  = !baseline_taken;
    do_up    = baseline_taken && !probe_up_done;
    do_down  = baseline_taken && probe_up_done && !improved && !probe_down_done;
    do_scale = baseline_taken && probe_up_done && !improved && probe_down_done;
    move_on  = baseline_taken && probe_up_done && (improved || probe_down_done);

    write_gain = do_up || do_down || do_scale;
    new_gain   = do_down ? sat_gain(gain_dn) : sat_gain(gain_up);

    if (int'(idx) == NUM_GAINS - 1) begin
      idx_next = '0;
    end else begin
      idx_next = idx + IDX_W'(1);
    end
    if (!move_on) begin
      idx_next = idx;
    end

    total_next = step_total;
    if (do_scale) begin
      total_next = step_total - {{(TOTAL_W-STEP_W){1'b0}}, step}
                              + {{(TOTAL_W-STEP_W){1'b0}}, scaled};
    end

    for (int i = 0; i < GAIN_FIELDS; i++) begin
      if (write_gain && int'(idx) == i) begin
        res_next.next_gain[i] = new_gain;
      end else begin
        res_next.next_gain[i] = stage.item.gain[i];
      end
    end
    res_next.step_total  = total_next;
    res_next.active_gain = ACT_W'(idx_next);
  end

  // Step register writes must only arrive while idle; the block itself does not enforce this.
  always_comb begin
    cfg_old = '0;
    for (int i = 0; i < NUM_GAINS; i++) begin
      if (int'(cfg_index) == i) begin
        cfg_old = steps[i];
      end
    end
    cfg_hit = cfg_write && (int'(cfg_index) < GAIN_FIELDS) && (int'(cfg_index) < NUM_GAINS);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      baseline_taken    <= 1'b0;
      probe_up_done     <= 1'b0;
      probe_down_done   <= 1'b0;
      idx               <= '0;
      best_error        <= ERR_RESET;
      baseline_distance <= '0;
      step_total        <= TOTAL_RESET;
      for (int i = 0; i < NUM_GAINS; i++) begin
        steps[i] <= (i < GAIN_FIELDS) ? STEP_RESET : '0;
      end
    end else if (cfg_hit) begin
      for (int i = 0; i < NUM_GAINS; i++) begin
        if (int'(cfg_index) == i) begin
          steps[i] <= cfg_data;
        end
      end
      step_total <= step_total - {{(TOTAL_W-STEP_W){1'b0}}, cfg_old}
                               + {{(TOTAL_W-STEP_W){1'b0}}, cfg_data};
    end else if (fire) begin
      if (do_base) begin
        baseline_taken    <= 1'b1;
        baseline_distance <= stage.item.trial_distance;
        best_error        <= stage.item.trial_error;
      end
      if (do_up) begin
        probe_up_done <= 1'b1;
      end
      if (do_down) begin
        probe_down_done <= 1'b1;
      end
      if (baseline_taken && probe_up_done && improved) begin
        best_error <= stage.item.trial_error;
      end
      if (do_scale) begin
        for (int i = 0; i < NUM_GAINS; i++) begin
          if (int'(idx) == i) begin
            steps[i] <= scaled;
          end
        end
      end
      if (move_on) begin
        probe_up_done   <= 1'b0;
        probe_down_done <= 1'b0;
      end
      idx        <= idx_next;
      step_total <= total_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_res <= res_next;
    end
  end

  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    int'(idx) < NUM_GAINS) else $error("tuning index out of range");

  a_down_after_up: assert property (@(posedge clk) disable iff (rst)
    probe_down_done |-> probe_up_done) else $error("down probe without up probe");

  a_up_after_base: assert property (@(posedge clk) disable iff (rst)
    probe_up_done |-> baseline_taken) else $error("probe before baseline");

  a_base_taken: assert property (@(posedge clk) disable iff (rst)
    (fire && !baseline_taken && !cfg_hit) |=> baseline_taken)
    else $error("baseline not recorded");

endmodule

// ===== rtl/twiddle_parameter_tuner_core.sv =====
// Top level of the twiddle parameter tuner: input register, update stage, port packing.
//
//  channel  dir  handshake          payload
//  s_*      in   s_tvalid/s_tready  s_tdata: trial_error, trial_distance, gain_0..2
//  m_*      out  m_tvalid/m_tready  m_tdata: next_gain_0..2, step_total, active_gain
//  cfg_*    in   cfg_write          cfg_index, cfg_data (initial_step_0..2)
//
// One trial per cycle sustained while m_tready stays high; a trial passes from the input transaction
// through the input register, then the update stage with one constant multiply into the result reg.
// rst is synchronous: state returns to no baseline, index 0, steps 1.0 in Q15.16.
// A stalled result holds the update stage; the input register still takes one trial.
module twiddle_parameter_tuner_core #(
  parameter int NUM_GAINS = tpt_pkg::NUM_GAINS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // [31:0] trial_error, [51:32] trial_distance, [83:52] gain_0, [115:84] gain_1,
  // [147:116] gain_2, [151:148] zero
  input  logic [tpt_pkg::S_TDATA_W-1:0]    s_tdata,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // [31:0] next_gain_0, [63:32] next_gain_1, [95:64] next_gain_2,
  // [128:96] step_total, [130:129] active_gain, [135:131] zero
  output logic [tpt_pkg::M_TDATA_W-1:0]    m_tdata,
  input  logic                             cfg_write,
  input  logic [tpt_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tpt_pkg::STEP_W-1:0]       cfg_data
);
  import tpt_pkg::*;

  localparam int ITEM_W = $bits(item_t);
  localparam int RES_W  = $bits(result_t);

  item_t   s_item;
  stage_t  stage;
  logic    take;
  result_t out_res;

  assign s_item  = item_t'(s_tdata[ITEM_W-1:0]);
  assign m_tdata = {{(M_TDATA_W-RES_W){1'b0}}, out_res};

  tpt_in_reg u_in_reg (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_item   (s_item),
    .take     (take),
    .stage    (stage)
  );

  tpt_update #(
    .NUM_GAINS (NUM_GAINS)
  ) u_update (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .stage     (stage),
    .take      (take),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (out_res)
  );

endmodule
